// ===== src/sha1_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared widths, constants, state encoding and round helpers for the SHA-1
// hashing engine and its channel interfaces.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 3;
  localparam int unsigned IndexW  = 3;
  localparam int unsigned RoundW  = 7;
  localparam int unsigned FillW   = 6;
  localparam int unsigned Rounds  = 80;

  localparam logic [CountW-1:0] MaxBytes   = 3'd4;
  localparam logic [IndexW-1:0] LastIndex  = 3'd4;
  localparam logic [FillW-1:0]  LenFill    = 6'd56;
  localparam logic [7:0]        PadByte    = 8'h80;

  // Initial chaining value, word A at index 0.
  localparam logic [4:0][WordW-1:0] InitVec = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_ABSORB = 7'b0000010,
    ST_PAD    = 7'b0000100,
    ST_ZERO   = 7'b0001000,
    ST_ROUND  = 7'b0010000,
    ST_FOLD   = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_e;

  typedef logic [4:0][WordW-1:0] chain_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                            input int unsigned n);
    return (x << n) | (x >> (WordW - n));
  endfunction

  // Boolean function of the round group.
  function automatic logic [WordW-1:0] round_f(input logic [RoundW-1:0] t,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [RoundW-1:0] t);
    logic [WordW-1:0] k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

// ===== src/sha1_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 channel interfaces
// Valid/ready channels for message words in and digest words out.
// ----------------------------------------------------------------------------
interface sha1_msg_if import sha1_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WordW-1:0]  msg_word;
  logic [CountW-1:0] byte_count;
  logic              last_word;

  modport source (output valid, msg_word, byte_count, last_word, input ready);
  modport sink   (input valid, msg_word, byte_count, last_word, output ready);
endinterface

interface sha1_digest_if import sha1_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WordW-1:0]  digest_word;
  logic [IndexW-1:0] word_index;
  logic              last_digest;
  logic              status;

  modport source (output valid, digest_word, word_index, last_digest, status,
                  input ready);
  modport sink   (input valid, digest_word, word_index, last_digest, status,
                  output ready);
endinterface

// ===== src/sha1_hash_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Streaming SHA-1 hasher with one shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
// The engine takes one message word per transaction on msg_i (big-endian,
// byte_count leading bytes valid, values above four treated as four) and,
// after the word marked last, returns the five digest words A to E as five
// transactions on digest_o, after which it starts a fresh message from the
// standard initial vector. After each input transaction its bytes are merged
// into the 64-byte block buffer, one buffer word or two, and no new word is
// accepted until that merge is done; whenever the block fills, the single
// round unit runs the 80 rounds one per cycle and then folds the result into
// the chaining value. On the last word the padding is written one word per
// cycle, pausing while a filled block is compressed; one or two blocks are
// compressed, and the digest words are then offered one per cycle while the
// consumer accepts them. No new message word is accepted until the final
// digest word has been taken. The status field flags a message whose bit
// length wrapped past 2^64 - 1.
// ----------------------------------------------------------------------------
module sha1_hash_engine import sha1_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sha1_msg_if.sink      msg_i,
  sha1_digest_if.source digest_o
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;
  state_e              ret_q, ret_d;       // where to continue after a fold
  logic [FillW-1:0]    fill_q, fill_d;     // bytes held in the current block
  logic [63:0]         bc_q, bc_d;         // message length in bits
  logic                ovf_q, ovf_d;
  logic [RoundW-1:0]   round_q, round_d;
  logic [IndexW-1:0]   out_idx_q, out_idx_d;
  chain_t              cv_q, cv_d;
  chain_t              wv_q, wv_d;         // working variables, A at index 0
  logic [CountW-1:0]   pend_cnt_q, pend_cnt_d;
  logic                pend_last_q, pend_last_d;
  logic [WordW-1:0]    pend_word_q, pend_word_d;

  // The block buffer doubles as the message schedule window: during the
  // rounds it shifts down by one word per cycle, so entry 0 is always the
  // schedule word of the current round.
  logic [WordW-1:0]    blk_q [16];

  // Buffer write port used while filling and padding.
  logic                wr_en;
  logic [3:0]          wr_idx;
  logic [3:0]          wr_be;              // bit j enables byte lane j
  logic [WordW-1:0]    wr_data;
  logic                len_wr;

  logic                start_cmp;
  state_e              cmp_ret;

  // Byte merge helpers.
  logic [1:0]          off;
  logic [CountW-1:0]   room;
  logic [CountW-1:0]   take;
  logic [CountW-1:0]   lane_end;
  logic [CountW-1:0]   rem;
  logic [CountW-1:0]   in_cnt;
  logic [FillW:0]      fill_sum;
  logic [64:0]         bc_sum;
  state_e              after_abs;

  // Round unit.
  logic [WordW-1:0]    w_next;
  logic [WordW-1:0]    t_sum;

  assign off      = fill_q[1:0];
  assign room     = MaxBytes - {1'b0, off};
  assign take     = (pend_cnt_q < room) ? pend_cnt_q : room;
  assign lane_end = {1'b0, off} + take;
  assign rem      = pend_cnt_q - take;
  assign in_cnt   = (msg_i.byte_count > MaxBytes) ? MaxBytes : msg_i.byte_count;
  assign bc_sum   = {1'b0, bc_q} + {59'd0, take, 3'b000};

  assign w_next = rotl(blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0], 1);
  assign t_sum  = rotl(wv_q[0], 5) + round_f(round_q, wv_q[1], wv_q[2], wv_q[3])
                  + wv_q[4] + round_k(round_q) + blk_q[0];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    fill_d      = fill_q;
    bc_d        = bc_q;
    ovf_d       = ovf_q;
    round_d     = round_q;
    out_idx_d   = out_idx_q;
    cv_d        = cv_q;
    wv_d        = wv_q;
    pend_cnt_d  = pend_cnt_q;
    pend_last_d = pend_last_q;
    pend_word_d = pend_word_q;
    wr_en       = 1'b0;
    wr_idx      = fill_q[5:2];
    wr_be       = 4'b0000;
    wr_data     = '0;
    len_wr      = 1'b0;
    start_cmp   = 1'b0;
    cmp_ret     = ST_IDLE;
    fill_sum    = {1'b0, fill_q};
    after_abs   = ST_IDLE;

    unique case (state_q)
      ST_IDLE: begin
        if (msg_i.valid) begin
          pend_word_d = msg_i.msg_word;
          pend_cnt_d  = in_cnt;
          pend_last_d = msg_i.last_word;
          state_d     = ST_ABSORB;
        end
      end

      // Merge as many pending bytes as fit into the current buffer word.
      ST_ABSORB: begin
        wr_en   = 1'b1;
        wr_data = pend_word_q >> {off, 3'b000};
        for (int j = 0; j < 4; j++) begin
          wr_be[j] = (3'(j) >= {1'b0, off}) && (3'(j) < lane_end);
        end
        fill_sum    = {1'b0, fill_q} + {4'd0, take};
        bc_d        = bc_sum[63:0];
        ovf_d       = ovf_q | bc_sum[64];
        pend_word_d = pend_word_q << {take, 3'b000};
        pend_cnt_d  = rem;
        if (rem != '0) begin
          after_abs = ST_ABSORB;
        end else if (pend_last_q) begin
          after_abs = ST_PAD;
        end else begin
          after_abs = ST_IDLE;
        end
        if (fill_sum[FillW]) begin
          fill_d    = '0;
          start_cmp = 1'b1;
          cmp_ret   = after_abs;
        end else begin
          fill_d  = fill_sum[FillW-1:0];
          state_d = after_abs;
        end
      end

      // Marker byte, with zeros in the remaining lanes of its word.
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_data = {PadByte, 24'd0} >> {off, 3'b000};
        for (int j = 0; j < 4; j++) begin
          wr_be[j] = (2'(j) >= off);
        end
        fill_sum = {1'b0, fill_q[5:2], 2'b00} + 7'd4;
        if (fill_sum[FillW]) begin
          fill_d    = '0;
          start_cmp = 1'b1;
          cmp_ret   = ST_ZERO;
        end else begin
          fill_d  = fill_sum[FillW-1:0];
          state_d = ST_ZERO;
        end
      end

      // Zero fill up to byte 56, then the bit length closes the last block.
      ST_ZERO: begin
        if (fill_q == LenFill) begin
          len_wr    = 1'b1;
          fill_d    = '0;
          start_cmp = 1'b1;
          cmp_ret   = ST_OUT;
        end else begin
          wr_en    = 1'b1;
          wr_be    = 4'b1111;
          fill_sum = {1'b0, fill_q} + 7'd4;
          if (fill_sum[FillW]) begin
            fill_d    = '0;
            start_cmp = 1'b1;
            cmp_ret   = ST_ZERO;
          end else begin
            fill_d = fill_sum[FillW-1:0];
          end
        end
      end

      ST_ROUND: begin
        wv_d[4] = wv_q[3];
        wv_d[3] = wv_q[2];
        wv_d[2] = rotl(wv_q[1], 30);
        wv_d[1] = wv_q[0];
        wv_d[0] = t_sum;
        round_d = round_q + 7'd1;
        if (round_q == RoundW'(Rounds - 1)) begin
          state_d = ST_FOLD;
        end
      end

      ST_FOLD: begin
        for (int i = 0; i < 5; i++) begin
          cv_d[i] = cv_q[i] + wv_q[i];
        end
        out_idx_d = '0;
        state_d   = ret_q;
      end

      ST_OUT: begin
        if (digest_o.ready) begin
          if (out_idx_q == LastIndex) begin
            cv_d      = InitVec;
            bc_d      = '0;
            ovf_d     = 1'b0;
            out_idx_d = '0;
            state_d   = ST_IDLE;
          end else begin
            out_idx_d = out_idx_q + 3'd1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Entering a compression loads the working variables from the chain.
    if (start_cmp) begin
      wv_d    = cv_q;
      round_d = '0;
      ret_d   = cmp_ret;
      state_d = ST_ROUND;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      fill_q      <= '0;
      bc_q        <= '0;
      ovf_q       <= 1'b0;
      round_q     <= '0;
      out_idx_q   <= '0;
      cv_q        <= InitVec;
      pend_cnt_q  <= '0;
      pend_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      fill_q      <= fill_d;
      bc_q        <= bc_d;
      ovf_q       <= ovf_d;
      round_q     <= round_d;
      out_idx_q   <= out_idx_d;
      cv_q        <= cv_d;
      pend_cnt_q  <= pend_cnt_d;
      pend_last_q <= pend_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wv_q        <= wv_d;
    pend_word_q <= pend_word_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        blk_q[i] <= blk_q[i+1];
      end
      blk_q[15] <= w_next;
    end else begin
      if (wr_en) begin
        for (int j = 0; j < 4; j++) begin
          if (wr_be[j]) begin
            blk_q[wr_idx][31-8*j -: 8] <= wr_data[31-8*j -: 8];
          end
        end
      end
      if (len_wr) begin
        blk_q[14] <= bc_q[63:32];
        blk_q[15] <= bc_q[31:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Channel outputs
  // --------------------------------------------------------------------------
  assign msg_i.ready          = (state_q == ST_IDLE);
  assign digest_o.valid       = (state_q == ST_OUT);
  assign digest_o.digest_word = cv_q[out_idx_q];
  assign digest_o.word_index  = out_idx_q;
  assign digest_o.last_digest = (out_idx_q == LastIndex);
  assign digest_o.status      = ovf_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The engine never takes a word while a digest is still on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(msg_i.ready && digest_o.valid))
    else $error("message accepted while digest pending");

  // Every compression starts on a block boundary.
  a_round_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (fill_q == '0))
    else $error("compression running with a partly filled block");

  // Taking the fifth digest word restarts the message state.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digest_o.valid && digest_o.ready && out_idx_q == LastIndex) |=>
      (state_q == ST_IDLE && bc_q == '0 && !ovf_q && cv_q == InitVec))
    else $error("engine not restarted after the digest");

  // A fold follows only the final round.
  a_fold_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FOLD) |-> ($past(state_q) == ST_ROUND &&
                              $past(round_q) == RoundW'(Rounds - 1)))
    else $error("fold entered before the last round");

endmodule
